// ===== hdl/cantp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN transport reassembly package
// Shared widths, frame and result codes, and the per-frame run plan type.
// ----------------------------------------------------------------------------
package cantp_pkg;

    localparam int ID_W     = 29;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 12;
    localparam int KIND_W   = 2;
    localparam int SLOTS    = 8;
    localparam int SLOT_W   = 3;
    localparam int COUNT_W  = 4;

    localparam logic [3:0] TYPE_SINGLE = 4'h0;
    localparam logic [3:0] TYPE_FIRST  = 4'h1;
    localparam logic [3:0] TYPE_CONSEC = 4'h2;

    localparam logic [KIND_W-1:0] KIND_FLOW_CONTROL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEGMENT      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SINGLE       = 2'd2;

    localparam logic [BYTE_W-1:0] FC_BYTE     = 8'h30;
    localparam logic [ID_W-1:0]   FC_ID_RESET = 29'h740;

    localparam logic [LEN_W-1:0] FF_PAYLOAD = 12'd6;
    localparam logic [LEN_W-1:0] CF_PAYLOAD = 12'd7;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        byte_t [SLOTS-1:0] bytes;
    } frame_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               fc_first;
        logic               end_valid;
        logic [SLOT_W-1:0]  end_slot;
        logic [KIND_W-1:0]  kind;
        logic [ID_W-1:0]    ident;
        byte_t [SLOTS-1:0]  bytes;
        logic [LEN_W-1:0]   rem_next;
        logic [ID_W-1:0]    open_id_next;
    } plan_t;

endpackage

// ===== hdl/cantp_frame_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Received frame channel
// Valid/ready channel that carries one CAN frame: identifier and eight bytes.
// ----------------------------------------------------------------------------
interface cantp_frame_if
    import cantp_pkg::*;
    ;

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   frame_id;
    logic [BYTE_W-1:0] frame_byte0;
    logic [BYTE_W-1:0] frame_byte1;
    logic [BYTE_W-1:0] frame_byte2;
    logic [BYTE_W-1:0] frame_byte3;
    logic [BYTE_W-1:0] frame_byte4;
    logic [BYTE_W-1:0] frame_byte5;
    logic [BYTE_W-1:0] frame_byte6;
    logic [BYTE_W-1:0] frame_byte7;

    modport source (
        output valid, frame_id, frame_byte0, frame_byte1, frame_byte2, frame_byte3,
               frame_byte4, frame_byte5, frame_byte6, frame_byte7,
        input  ready
    );

    modport sink (
        input  valid, frame_id, frame_byte0, frame_byte1, frame_byte2, frame_byte3,
               frame_byte4, frame_byte5, frame_byte6, frame_byte7,
        output ready
    );

endinterface

// ===== hdl/cantp_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reassembly result channel
// Valid/ready channel that carries one result byte with its message tags.
// ----------------------------------------------------------------------------
interface cantp_result_if
    import cantp_pkg::*;
    ;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   message_ident;
    logic [BYTE_W-1:0] data_byte;
    logic              message_end;
    logic              run_last;

    modport source (
        output valid, kind, message_ident, data_byte, message_end, run_last,
        input  ready
    );

    modport sink (
        input  valid, kind, message_ident, data_byte, message_end, run_last,
        output ready
    );

endinterface

// ===== hdl/cantp_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame decoder
// Classifies one frame and builds the list of result bytes it causes,
// together with the next transport state.
// ----------------------------------------------------------------------------
module cantp_decode
    import cantp_pkg::*;
(
    input  frame_t           frame,
    input  logic [LEN_W-1:0] rem,
    input  logic [ID_W-1:0]  open_id,
    output plan_t            plan
);

    logic [3:0]       frame_type;
    logic [LEN_W-1:0] first_len;
    logic [LEN_W-1:0] first_take;
    logic [LEN_W-1:0] consec_take;

    assign frame_type  = frame.bytes[0][7:4];
    assign first_len   = {frame.bytes[0][3:0], frame.bytes[1]};
    assign first_take  = (first_len > FF_PAYLOAD) ? FF_PAYLOAD : first_len;
    assign consec_take = (rem > CF_PAYLOAD) ? CF_PAYLOAD : rem;

    always_comb
    begin
        plan              = '0;
        plan.kind         = KIND_SEGMENT;
        plan.ident        = frame.id;
        plan.rem_next     = rem;
        plan.open_id_next = open_id;
        case (frame_type)
            TYPE_FIRST:
            begin
                plan.count        = first_take[COUNT_W-1:0] + 4'd1;
                plan.fc_first     = 1'b1;
                plan.end_valid    = (first_len != '0) && (first_len <= FF_PAYLOAD);
                plan.end_slot     = first_len[SLOT_W-1:0];
                plan.rem_next     = first_len - first_take;
                plan.open_id_next = frame.id;
                for (int i = 1; i < SLOTS; i++)
                begin
                    plan.bytes[i] = frame.bytes[(i + 1) % SLOTS];
                end
            end
            TYPE_CONSEC:
            begin
                if (rem != '0)
                begin
                    plan.count     = consec_take[COUNT_W-1:0];
                    plan.ident     = open_id;
                    plan.end_valid = (rem <= CF_PAYLOAD);
                    plan.end_slot  = rem[SLOT_W-1:0] - 3'd1;
                    plan.rem_next  = rem - consec_take;
                    for (int i = 0; i < SLOTS - 1; i++)
                    begin
                        plan.bytes[i] = frame.bytes[i + 1];
                    end
                end
            end
            TYPE_SINGLE:
            begin
                plan.count     = 4'd8;
                plan.kind      = KIND_SINGLE;
                plan.end_valid = 1'b1;
                plan.end_slot  = 3'd7;
                plan.bytes     = frame.bytes;
            end
            default:
            begin
                plan.count = '0;
            end
        endcase
    end

endmodule

// ===== hdl/can_transport_reassembly.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN transport reassembly
// The first result of a frame is valid in the cycle after it is accepted.
// Throughput: one result per cycle while result.ready is high. A frame causes
// up to eight results; the next frame is accepted as its last one is taken.
// Frames with no results produce no output. Reset is asynchronous and
// closes any open message and loads the flow-control id with 0x740.
// ----------------------------------------------------------------------------
module can_transport_reassembly
    import cantp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    cantp_frame_if.sink          frame,
    cantp_result_if.source       result,
    input  logic                 cfg_wr_en,
    input  logic [ID_W-1:0]      cfg_wr_data
);

    frame_t             frame_in;
    plan_t              plan;
    logic               in_fire;
    logic               out_fire;
    logic               run_busy;
    logic               run_at_last;
    logic               fc_slot;

    logic [ID_W-1:0]    fc_id_reg;
    logic [LEN_W-1:0]   rem_reg;
    logic [ID_W-1:0]    open_id_reg;
    logic [COUNT_W-1:0] run_count_reg;
    logic [SLOT_W-1:0]  run_slot_reg;
    logic               run_fc_reg;
    logic               run_end_valid_reg;
    logic [SLOT_W-1:0]  run_end_slot_reg;
    logic [KIND_W-1:0]  run_kind_reg;
    logic [ID_W-1:0]    run_ident_reg;
    byte_t [SLOTS-1:0]  run_bytes_reg;

    logic [COUNT_W-1:0] run_count_next;
    logic [SLOT_W-1:0]  run_slot_next;

    assign frame_in.id       = frame.frame_id;
    assign frame_in.bytes[0] = frame.frame_byte0;
    assign frame_in.bytes[1] = frame.frame_byte1;
    assign frame_in.bytes[2] = frame.frame_byte2;
    assign frame_in.bytes[3] = frame.frame_byte3;
    assign frame_in.bytes[4] = frame.frame_byte4;
    assign frame_in.bytes[5] = frame.frame_byte5;
    assign frame_in.bytes[6] = frame.frame_byte6;
    assign frame_in.bytes[7] = frame.frame_byte7;

    cantp_decode u_decode (
        .frame   (frame_in),
        .rem     (rem_reg),
        .open_id (open_id_reg),
        .plan    (plan)
    );

    assign run_busy    = (run_count_reg != '0);
    assign run_at_last = ({1'b0, run_slot_reg} + 4'd1) == run_count_reg;
    assign out_fire    = result.valid && result.ready;
    assign frame.ready = !run_busy || (result.ready && run_at_last);
    assign in_fire     = frame.valid && frame.ready;

    always_comb
    begin
        run_count_next = run_count_reg;
        run_slot_next  = run_slot_reg;
        if (in_fire)
        begin
            run_count_next = plan.count;
            run_slot_next  = '0;
        end
        else if (out_fire)
        begin
            if (run_at_last)
            begin
                run_count_next = '0;
                run_slot_next  = '0;
            end
            else
            begin
                run_slot_next = run_slot_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_id_reg     <= FC_ID_RESET;
            rem_reg       <= '0;
            open_id_reg   <= '0;
            run_count_reg <= '0;
            run_slot_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                fc_id_reg <= cfg_wr_data;
            end
            if (in_fire)
            begin
                rem_reg     <= plan.rem_next;
                open_id_reg <= plan.open_id_next;
            end
            run_count_reg <= run_count_next;
            run_slot_reg  <= run_slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            run_fc_reg        <= plan.fc_first;
            run_end_valid_reg <= plan.end_valid;
            run_end_slot_reg  <= plan.end_slot;
            run_kind_reg      <= plan.kind;
            run_ident_reg     <= plan.ident;
            run_bytes_reg     <= plan.bytes;
        end
    end

    assign fc_slot = run_fc_reg && (run_slot_reg == '0);

    assign result.valid         = run_busy;
    assign result.kind          = fc_slot ? KIND_FLOW_CONTROL : run_kind_reg;
    assign result.message_ident = fc_slot ? fc_id_reg : run_ident_reg;
    assign result.data_byte     = fc_slot ? FC_BYTE : run_bytes_reg[run_slot_reg];
    assign result.message_end   = !fc_slot && run_end_valid_reg
                                  && (run_slot_reg == run_end_slot_reg);
    assign result.run_last      = run_at_last;

    a_slot_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        run_busy |-> ({1'b0, run_slot_reg} < run_count_reg))
        else $error("result slot beyond the end of the run");

    a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (plan.count != '0) |=> result.valid && (run_slot_reg == '0))
        else $error("accepted frame did not start its run at slot zero");

    a_rem_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (frame.frame_byte0[7:4] != TYPE_FIRST) |=> rem_reg <= $past(rem_reg))
        else $error("remaining length grew without a first frame");

    a_end_not_fc: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.message_end |-> result.kind != KIND_FLOW_CONTROL)
        else $error("flow-control request marked as message end");

endmodule
